// ===== hw/rtl/lfbe_pkg.sv =====
// Shared types, constants and the divider step for the LED frame brightness encoder.
// Used by every module under hw/rtl; depends on nothing else.
`default_nettype none

package lfbe_pkg;

    // Frame layout
    localparam int HEADER_BYTES = 4;
    localparam int HDR_TOTAL    = HEADER_BYTES + 3;
    localparam int LED_BYTES    = 4;

    // Field widths
    localparam int CNT_W  = 10;
    localparam int COL_W  = 16;
    localparam int FSZ_W  = 6;
    localparam int LEN_W  = 12;
    localparam int A_W    = 5;
    localparam int NUM_W  = 29;
    localparam int DV_W   = 28;
    localparam int IDX_W  = 6;

    // Byte codes
    localparam logic [7:0] SYNC_BYTE   = 8'h44;
    localparam logic [7:0] BRIGHT_MARK = 8'hE0;
    localparam logic [7:0] FOOTER_BYTE = 8'hFF;
    localparam logic [7:0] ZERO_BYTE   = 8'h00;

    // Arithmetic constants
    localparam logic [15:0] FULL_SCALE = 16'hFFFF;
    localparam logic [8:0]  LEN_MOD    = 9'd255;
    localparam logic [12:0] COL_SCALE  = 13'd7905;

    // Register map
    localparam logic REG_LED_COUNT = 1'b0;

    localparam int QUEUE_DEPTH = 2;

    // Per-LED control information worked out by the front end
    typedef struct packed {
        logic             hdr;
        logic             last;
        logic [FSZ_W-1:0] fsz;
        logic [7:0]       len_lo;
        logic [3:0]       len_hi;
        logic [A_W-1:0]   a;
    } info_t;

    // Queue entry: control information plus the scaled colour numerators
    typedef struct packed {
        info_t            info;
        logic [NUM_W-1:0] num_b;
        logic [NUM_W-1:0] num_g;
        logic [NUM_W-1:0] num_r;
    } entry_t;

    // Finished LED handed from the divider to the serialiser
    typedef struct packed {
        info_t      info;
        logic [7:0] col_b;
        logic [7:0] col_g;
        logic [7:0] col_r;
    } res_t;

    typedef struct packed {
        logic [NUM_W-1:0] rem;
        logic [1:0]       bits;
    } step_t;

    // Two restoring division steps against the shifted divisor and its half.
    function automatic step_t div_step2(logic [NUM_W-1:0] rem, logic [DV_W-1:0] dv);
        logic [NUM_W-1:0] d1;
        logic [NUM_W-1:0] d2;
        logic [NUM_W-1:0] r1;
        logic             t1;
        logic             t2;
        step_t            s;
        d1     = {1'b0, dv};
        d2     = {2'b00, dv[DV_W-1:1]};
        t1     = rem >= d1;
        r1     = t1 ? rem - d1 : rem;
        t2     = r1 >= d2;
        s.rem  = t2 ? r1 - d2 : r1;
        s.bits = {t1, t2};
        return s;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/led_frame_brightness_encoder.sv =====
// LED frame brightness encoder, top level.
// Input channel: one LED colour (red, green, blue, 16 bits each, 65535 = full
// scale) per transfer on in_valid / in_ready.
// Output channel: one frame byte per transfer on out_valid / out_ready, with
// frame_end on the last footer byte and run_end on the last byte of each LED.
// The first LED of a frame brings seven header bytes, every LED four bytes, and
// the LED that closes the frame the footer bytes.
// Configuration: APB register led_count at address 0 (reset value 1).
// Throughput: set by the one-byte output port and by the colour divider, which
// retires two quotient bits per cycle unless a full result slot holds its last
// step; header and footer bytes add output transfers to their LED.
// A two-entry queue and a result slot let input transfers continue while the
// receiver stalls, until both are full; then in_ready drops.
// Reset empties the pipeline, returns to the start of a frame and sets
// led_count to 1.
// Dependencies: lfbe_pkg, lfbe_front, lfbe_queue, lfbe_div, lfbe_ser.
`default_nettype none

module led_frame_brightness_encoder #(
    parameter int MAX_LEDS = 512
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [15:0] red,
    input  logic [15:0] green,
    input  logic [15:0] blue,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic        frame_end,
    output logic        run_end
);
    import lfbe_pkg::*;

    logic [CNT_W-1:0] led_count_reg;
    logic [CNT_W-1:0] led_count_next;
    logic             q_push;
    logic             q_pop;
    logic             q_full;
    logic             q_empty;
    entry_t           q_wr;
    entry_t           q_rd;
    logic             res_valid;
    logic             res_take;
    res_t             res;

    // Configuration register
    assign pready = 1'b1;

    always_comb
    begin
        led_count_next = led_count_reg;
        if (psel && penable && pwrite && (paddr[2] == REG_LED_COUNT))
            led_count_next = pwdata[CNT_W-1:0];
        prdata = (paddr[2] == REG_LED_COUNT) ? {{(32-CNT_W){1'b0}}, led_count_reg} : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            led_count_reg <= CNT_W'(1);
        else
            led_count_reg <= led_count_next;
    end

    // Front end, queue, divider and serialiser
    lfbe_front #(
        .MAX_LEDS (MAX_LEDS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .red       (red),
        .green     (green),
        .blue      (blue),
        .led_count (led_count_reg),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_data    (q_wr)
    );

    lfbe_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .wr_data (q_wr),
        .pop     (q_pop),
        .rd_data (q_rd),
        .full    (q_full),
        .empty   (q_empty)
    );

    lfbe_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (!q_empty),
        .q_data    (q_rd),
        .q_pop     (q_pop),
        .res_valid (res_valid),
        .res       (res),
        .res_take  (res_take)
    );

    lfbe_ser u_ser (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .res_take  (res_take),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_byte  (out_byte),
        .frame_end (frame_end),
        .run_end   (run_end)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/lfbe_front.sv =====
// Front end: accepts LED colour transfers, tracks the position in the frame and
// works out header, brightness and footer information. Depends on lfbe_pkg.
`default_nettype none

module lfbe_front #(
    parameter int MAX_LEDS = 512
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [15:0]                 red,
    input  logic [15:0]                 green,
    input  logic [15:0]                 blue,
    input  logic [lfbe_pkg::CNT_W-1:0]  led_count,
    input  logic                        q_full,
    output logic                        q_push,
    output lfbe_pkg::entry_t            q_data
);
    import lfbe_pkg::*;

    localparam int PosW = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
    localparam logic [CNT_W-1:0] MaxCount = CNT_W'(MAX_LEDS);

    logic [PosW-1:0]  pos_reg;
    logic [PosW-1:0]  pos_next;
    logic [CNT_W-1:0] n_eff;
    logic [CNT_W:0]   np1;
    logic [CNT_W-1:0] half;
    logic [CNT_W-1:0] fsum;
    logic [FSZ_W-1:0] fsz;
    logic [LEN_W-1:0] len;
    logic [3:0]       len_q0;
    logic [8:0]       len_r;
    logic             len_corr;
    logic [15:0]      max_rg;
    logic [15:0]      m;
    logic [20:0]      x;
    logic [21:0]      y;
    logic [5:0]       a_q0;
    logic [16:0]      a_r;
    logic             a_corr;
    logic [5:0]       a_sum;
    logic [CNT_W:0]   pos_inc;
    logic             last;

    assign in_ready = !q_full;
    assign q_push   = in_valid && !q_full;

    // Effective LED count, saturated into the supported range
    always_comb
    begin
        if (led_count == '0)
            n_eff = CNT_W'(1);
        else if (led_count > MaxCount)
            n_eff = MaxCount;
        else
            n_eff = led_count;
    end

    // Footer size and total frame length, with the length split by 255
    always_comb
    begin
        np1      = {1'b0, n_eff} + (CNT_W+1)'(1);
        half     = np1[CNT_W:1];
        fsum     = half + CNT_W'(7);
        fsz      = fsum[FSZ_W+2:3];
        len      = LEN_W'(HEADER_BYTES) + LEN_W'(fsz) + {n_eff, 2'b00};
        len_q0   = len[11:8];
        len_r    = {1'b0, len[7:0]} + {5'b0, len_q0};
        len_corr = len_r >= LEN_MOD;
    end

    // Brightness: ceil(max * 31 / 65535), dividing by 2^16 - 1 with one correction
    always_comb
    begin
        max_rg = (green > red) ? green : red;
        m      = (blue > max_rg) ? blue : max_rg;
        x      = {m, 5'b00000} - {5'b00000, m};
        y      = {1'b0, x} + (22'(FULL_SCALE) - 22'd1);
        a_q0   = y[21:16];
        a_r    = {1'b0, y[15:0]} + 17'(a_q0);
        a_corr = a_r >= 17'(FULL_SCALE);
        a_sum  = a_q0 + 6'(a_corr);
    end

    // Position in the frame
    always_comb
    begin
        pos_inc  = (CNT_W+1)'(pos_reg) + (CNT_W+1)'(1);
        last     = pos_inc >= {1'b0, n_eff};
        pos_next = pos_reg;
        if (q_push)
            pos_next = last ? '0 : pos_inc[PosW-1:0];
    end

    // Queue entry
    always_comb
    begin
        q_data.info.hdr    = (pos_reg == '0);
        q_data.info.last   = last;
        q_data.info.fsz    = fsz;
        q_data.info.len_hi = len_q0 + 4'(len_corr);
        q_data.info.len_lo = len_corr ? 8'(len_r - LEN_MOD) : len_r[7:0];
        q_data.info.a      = a_sum[A_W-1:0];
        q_data.num_b       = NUM_W'(blue) * NUM_W'(COL_SCALE);
        q_data.num_g       = NUM_W'(green) * NUM_W'(COL_SCALE);
        q_data.num_r       = NUM_W'(red) * NUM_W'(COL_SCALE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pos_reg <= '0;
        else
            pos_reg <= pos_next;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/lfbe_queue.sv =====
// Two-entry queue that decouples the front end from the divider.
// Depends on lfbe_pkg for the entry type and depth.
`default_nettype none

module lfbe_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  lfbe_pkg::entry_t  wr_data,
    input  logic              pop,
    output lfbe_pkg::entry_t  rd_data,
    output logic              full,
    output logic              empty
);
    import lfbe_pkg::*;

    localparam int PtrW = $clog2(QUEUE_DEPTH);

    entry_t          slot_reg [QUEUE_DEPTH];
    logic [PtrW-1:0] wr_ptr_reg;
    logic [PtrW-1:0] wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg;
    logic [PtrW-1:0] rd_ptr_next;
    logic [PtrW:0]   count_reg;
    logic [PtrW:0]   count_next;

    assign full    = (count_reg == (PtrW+1)'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = slot_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + PtrW'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + PtrW'(1) : rd_ptr_reg;
        count_next  = count_reg + (PtrW+1)'(push) - (PtrW+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= wr_data;
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (push && full) |-> pop)
        else $error("queue written while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("queue read while empty");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/lfbe_div.sv =====
// Colour divider: three lanes share one divisor a * 65535 and retire two quotient
// bits per cycle, stalling only on a full result slot. Depends on lfbe_pkg.
`default_nettype none

module lfbe_div (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    input  lfbe_pkg::entry_t  q_data,
    output logic              q_pop,
    output logic              res_valid,
    output lfbe_pkg::res_t    res,
    input  logic              res_take
);
    import lfbe_pkg::*;

    logic             busy_reg;
    logic             busy_next;
    logic [1:0]       cnt_reg;
    logic [1:0]       cnt_next;
    logic             res_valid_reg;
    logic             res_valid_next;
    info_t            info_reg;
    logic [NUM_W-1:0] rem_reg [3];
    logic [7:0]       quo_reg [3];
    logic [DV_W-1:0]  dv_reg;
    res_t             res_reg;
    step_t            st [3];
    logic [7:0]       quo_new [3];
    logic [NUM_W-1:0] num_in [3];
    logic [20:0]      divisor;
    logic             slot_free;
    logic             last_step;
    logic             advance;
    logic             done;
    logic             load;

    assign res_valid = res_valid_reg;
    assign res       = res_reg;
    assign q_pop     = load;

    // Handshake between the iteration counter, the queue and the result slot
    always_comb
    begin
        slot_free = !res_valid_reg || res_take;
        last_step = busy_reg && (cnt_reg == 2'd3);
        advance   = busy_reg && (!last_step || slot_free);
        done      = last_step && slot_free;
        load      = q_valid && (!busy_reg || done);
    end

    // Lane steps; lanes are blue, green, red in that order
    always_comb
    begin
        num_in[0] = q_data.num_b;
        num_in[1] = q_data.num_g;
        num_in[2] = q_data.num_r;
        divisor   = {q_data.info.a, 16'h0000} - 21'(q_data.info.a);
        for (int i = 0; i < 3; i++)
        begin
            st[i]      = div_step2(rem_reg[i], dv_reg);
            quo_new[i] = {quo_reg[i][5:0], st[i].bits};
        end
    end

    // Control state
    always_comb
    begin
        busy_next      = busy_reg;
        cnt_next       = cnt_reg;
        res_valid_next = res_valid_reg;
        if (res_take)
            res_valid_next = 1'b0;
        if (done)
        begin
            res_valid_next = 1'b1;
            busy_next      = 1'b0;
        end
        if (advance)
            cnt_next = cnt_reg + 2'd1;
        if (load)
        begin
            busy_next = 1'b1;
            cnt_next  = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            cnt_reg       <= 2'd0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            cnt_reg       <= cnt_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Datapath: remainders, quotients and the result slot
    always_ff @(posedge clk)
    begin
        if (done)
        begin
            res_reg.info  <= info_reg;
            res_reg.col_b <= (info_reg.a == '0) ? ZERO_BYTE : quo_new[0];
            res_reg.col_g <= (info_reg.a == '0) ? ZERO_BYTE : quo_new[1];
            res_reg.col_r <= (info_reg.a == '0) ? ZERO_BYTE : quo_new[2];
        end
        if (load)
        begin
            info_reg <= q_data.info;
            dv_reg   <= {divisor, 7'b0000000};
            for (int i = 0; i < 3; i++)
            begin
                rem_reg[i] <= num_in[i];
                quo_reg[i] <= 8'h00;
            end
        end
        else if (advance)
        begin
            dv_reg <= {2'b00, dv_reg[DV_W-1:2]};
            for (int i = 0; i < 3; i++)
            begin
                rem_reg[i] <= st[i].rem;
                quo_reg[i] <= quo_new[i];
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_hold_on_full_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (last_step && !slot_free) |=> (busy_reg && cnt_reg == 2'd3))
        else $error("divider moved on while the result slot was occupied");
    a_dark_led_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_reg.info.a == '0) |->
            (res_reg.col_b == ZERO_BYTE && res_reg.col_g == ZERO_BYTE &&
             res_reg.col_r == ZERO_BYTE))
        else $error("dark LED produced a non-zero colour byte");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/lfbe_ser.sv =====
// Byte serialiser: turns one finished LED into header, LED and footer bytes, one
// per cycle unless the receiver stalls, into a registered output stage. Depends on lfbe_pkg.
`default_nettype none

module lfbe_ser (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            res_valid,
    input  lfbe_pkg::res_t  res,
    output logic            res_take,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [7:0]      out_byte,
    output logic            frame_end,
    output logic            run_end
);
    import lfbe_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_HDR,
        S_LED,
        S_FTR
    } state_t;

    state_t           state_reg;
    state_t           state_next;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    res_t             job_reg;
    res_t             job_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [7:0]       out_byte_reg;
    logic [7:0]       out_byte_next;
    logic             frame_end_reg;
    logic             frame_end_next;
    logic             run_end_reg;
    logic             run_end_next;
    logic             emit_en;
    logic [7:0]       cur_byte;
    logic             cur_fend;
    logic             last_byte;

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign frame_end = frame_end_reg;
    assign run_end   = run_end_reg;

    assign emit_en  = (state_reg != S_IDLE) && (!out_valid_reg || out_ready);
    assign res_take = res_valid && ((state_reg == S_IDLE) || (emit_en && last_byte));

    // Current byte of the job
    always_comb
    begin
        cur_byte  = ZERO_BYTE;
        cur_fend  = 1'b0;
        last_byte = 1'b0;
        unique case (state_reg)
            S_HDR:
            begin
                unique case (idx_reg)
                    IDX_W'(0): cur_byte = SYNC_BYTE;
                    IDX_W'(1): cur_byte = job_reg.info.len_lo;
                    IDX_W'(2): cur_byte = {4'h0, job_reg.info.len_hi};
                    default:   cur_byte = ZERO_BYTE;
                endcase
            end
            S_LED:
            begin
                unique case (idx_reg[1:0])
                    2'd0:    cur_byte = BRIGHT_MARK | {3'b000, job_reg.info.a};
                    2'd1:    cur_byte = job_reg.col_b;
                    2'd2:    cur_byte = job_reg.col_g;
                    default: cur_byte = job_reg.col_r;
                endcase
                last_byte = (idx_reg == IDX_W'(LED_BYTES - 1)) && !job_reg.info.last;
            end
            S_FTR:
            begin
                cur_byte  = FOOTER_BYTE;
                cur_fend  = (idx_reg == job_reg.info.fsz - IDX_W'(1));
                last_byte = cur_fend;
            end
            default:
            begin
                cur_byte = ZERO_BYTE;
            end
        endcase
    end

    // Sequencing and the output stage
    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        job_next       = job_reg;
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        frame_end_next = frame_end_reg;
        run_end_next   = run_end_reg;

        if (emit_en)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = cur_byte;
            frame_end_next = cur_fend;
            run_end_next   = last_byte;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (emit_en)
        begin
            if (last_byte)
            begin
                state_next = S_IDLE;
            end
            else
            begin
                unique case (state_reg)
                    S_HDR:
                    begin
                        if (idx_reg == IDX_W'(HDR_TOTAL - 1))
                        begin
                            state_next = S_LED;
                            idx_next   = '0;
                        end
                        else
                        begin
                            idx_next = idx_reg + IDX_W'(1);
                        end
                    end
                    S_LED:
                    begin
                        if (idx_reg == IDX_W'(LED_BYTES - 1))
                        begin
                            state_next = S_FTR;
                            idx_next   = '0;
                        end
                        else
                        begin
                            idx_next = idx_reg + IDX_W'(1);
                        end
                    end
                    default:
                    begin
                        idx_next = idx_reg + IDX_W'(1);
                    end
                endcase
            end
        end

        if (res_take)
        begin
            job_next   = res;
            state_next = res.info.hdr ? S_HDR : S_LED;
            idx_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            job_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_byte_reg  <= ZERO_BYTE;
            frame_end_reg <= 1'b0;
            run_end_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            job_reg       <= job_next;
            out_valid_reg <= out_valid_next;
            out_byte_reg  <= out_byte_next;
            frame_end_reg <= frame_end_next;
            run_end_reg   <= run_end_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_frame_end_closes_run: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && frame_end_reg) |-> run_end_reg)
        else $error("frame end without end of run");
    a_footer_only_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FTR) |-> job_reg.info.last)
        else $error("footer started for an LED that does not close the frame");
`endif

endmodule

`default_nettype wire

// ===== sim/tb_led_frame_brightness_encoder.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the LED frame brightness encoder: feeds LED colours and
// led_count writes, predicts every frame byte and compares the output stream.
// Depends on lfbe_pkg and led_frame_brightness_encoder.

module tb_led_frame_brightness_encoder;
    import lfbe_pkg::*;

    localparam int MAX_LEDS    = 512;
    localparam int REG_UNUSED  = 1;     // register index with nothing behind it
    localparam int SETTLE_CYC  = 20;
    localparam int MAX_REPORTS = 40;
    localparam int RANDOM_LEDS = 215;

    typedef struct packed {
        logic [15:0] r;
        logic [15:0] g;
        logic [15:0] b;
    } colour_t;

    typedef struct packed {
        logic [7:0] data;
        logic       fend;
        logic       rend;
    } frame_byte_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [15:0] red = '0;
    logic [15:0] green = '0;
    logic [15:0] blue = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [7:0]  out_byte;
    logic        frame_end;
    logic        run_end;

    // Stimulus and prediction state
    colour_t     leds_pending[$];
    frame_byte_t frame_bytes_due[$];
    logic [9:0]  led_count_reg = 10'd1;
    int          led_pos = 0;
    logic        in_taken = 1'b0;
    logic        calm = 1'b0;
    int          leds_queued = 0;
    int          leds_accepted = 0;
    int          bytes_checked = 0;
    int          frames_seen = 0;
    int          reg_writes = 0;
    int          errors = 0;

    led_frame_brightness_encoder u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .red       (red),
        .green     (green),
        .blue      (blue),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_byte  (out_byte),
        .frame_end (frame_end),
        .run_end   (run_end)
    );

    // Clock generation.
    always #5 clk = ~clk;

    // Print one line per mismatch, up to a limit, and count every one.
    task automatic report_mismatch(input string what, input int got, input int want);
        errors++;
        if (errors <= MAX_REPORTS)
            $display("MISMATCH at %0t ns: %s got 0x%0h want 0x%0h", $time, what, got, want);
    endtask

    // Colour byte scaled against the LED's own brightness; a dark LED gives zero.
    function automatic logic [7:0] scale_colour(input logic [15:0] v, input int bright);
        longint num;
        longint q;
        if (bright == 0)
            return 8'h00;
        num = v;
        q   = (num * 31 * 255) / (longint'(bright) * 65535);
        if (q > 255)
            q = 255;
        return q[7:0];
    endfunction

    // Work out every byte that one LED transfer causes and queue it for checking.
    task automatic encode_led(input colour_t c);
        int          n;
        int          fsz;
        int          len;
        int          peak;
        int          bright;
        logic [7:0]  b8;
        logic        fe;
        frame_byte_t run[$];
        frame_byte_t t;
        // Effective count saturates to 1..MAX_LEDS.
        n = led_count_reg;
        if (n < 1)
            n = 1;
        if (n > MAX_LEDS)
            n = MAX_LEDS;
        fsz = ((n + 1) / 2 + 7) / 8;
        // Header before the first LED of a frame.
        if (led_pos == 0)
        begin
            len = HEADER_BYTES + fsz + LED_BYTES * n;
            run.push_back({SYNC_BYTE, 2'b00});
            b8 = 8'(len % 255);
            run.push_back({b8, 2'b00});
            b8 = 8'(len / 255);
            run.push_back({b8, 2'b00});
            for (int i = 0; i < HEADER_BYTES; i++)
                run.push_back({ZERO_BYTE, 2'b00});
        end
        // Brightness from the brightest channel, rounded up to 0..31.
        peak = c.r;
        if (c.g > peak)
            peak = c.g;
        if (c.b > peak)
            peak = c.b;
        bright = (peak * 31 + 65534) / 65535;
        b8 = 8'(bright);
        run.push_back({BRIGHT_MARK | b8, 2'b00});
        run.push_back({scale_colour(c.b, bright), 2'b00});
        run.push_back({scale_colour(c.g, bright), 2'b00});
        run.push_back({scale_colour(c.r, bright), 2'b00});
        // Footer once the count in force is reached.
        if (led_pos + 1 >= n)
        begin
            for (int i = 0; i < fsz; i++)
            begin
                fe = (i == fsz - 1);
                run.push_back({FOOTER_BYTE, fe, 1'b0});
            end
            led_pos = 0;
        end
        else
        begin
            led_pos = (led_pos + 1) % MAX_LEDS;
        end
        // The last byte of the run carries run_end.
        foreach (run[i])
        begin
            t      = run[i];
            t.rend = (i == run.size() - 1);
            frame_bytes_due.push_back(t);
        end
    endtask

    // Monitor: records accepted LED transfers and checks each output transfer.
    always @(posedge clk)
    begin : monitor
        frame_byte_t got;
        frame_byte_t want;
        in_taken <= in_valid && in_ready;
        if (rst_n && in_valid && in_ready)
        begin
            encode_led({red, green, blue});
            leds_accepted++;
        end
        if (rst_n && out_valid && out_ready)
        begin
            got = {out_byte, frame_end, run_end};
            if (frame_bytes_due.size() == 0)
            begin
                report_mismatch("byte with nothing expected", got, 0);
            end
            else
            begin
                want = frame_bytes_due.pop_front();
                if (got.data !== want.data)
                    report_mismatch("out_byte", got.data, want.data);
                if (got.fend !== want.fend)
                    report_mismatch("frame_end", got.fend, want.fend);
                if (got.rend !== want.rend)
                    report_mismatch("run_end", got.rend, want.rend);
                bytes_checked++;
            end
            if (frame_end === 1'b1)
                frames_seen++;
        end
    end

    // Driver: presents the next pending LED once the previous transfer is done,
    // and stalls the output side at random.
    always @(negedge clk)
    begin : led_driver
        colour_t c;
        if (rst_n && (!in_valid || in_taken))
        begin
            if (leds_pending.size() != 0 && (calm || $urandom_range(99) >= 26))
            begin
                c = leds_pending.pop_front();
                in_valid <= 1'b1;
                red      <= c.r;
                green    <= c.g;
                blue     <= c.b;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
        out_ready <= rst_n && (calm || $urandom_range(99) >= 26);
    end

    task automatic send_led(input logic [15:0] r, input logic [15:0] g, input logic [15:0] b);
        colour_t c;
        c.r = r;
        c.g = g;
        c.b = b;
        leds_pending.push_back(c);
        leds_queued++;
    endtask

    // Wait until every LED has been taken and every byte has arrived, then settle.
    task automatic drain();
        while (leds_accepted != leds_queued || frame_bytes_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYC) @(negedge clk);
    endtask

    // APB write: setup cycle, then access cycle; the register takes the value
    // at the edge where the access completes. The read data is checked afterwards.
    task automatic apb_write(input int idx, input logic [31:0] value);
        logic [2:0]  addr;
        logic [31:0] rd_want;
        addr = 3'(idx * 4);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (idx == REG_LED_COUNT)
            led_count_reg = value[9:0];
        reg_writes++;
        rd_want = (idx == REG_LED_COUNT) ? {22'h0, led_count_reg} : 32'h0;
        @(negedge clk);
        if (prdata !== rd_want)
            report_mismatch("prdata", int'(prdata), int'(rd_want));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // A random colour: full-range values in half the cases, with dark, full, dim and
    // single-channel LEDs mixed in.
    function automatic colour_t random_colour();
        colour_t c;
        c.r = 16'($urandom_range(16'hFFFF));
        c.g = 16'($urandom_range(16'hFFFF));
        c.b = 16'($urandom_range(16'hFFFF));
        case ($urandom_range(7))
            0: c = '0;
            1: c = '1;
            2:
            begin
                c.r = 16'($urandom_range(2200));
                c.g = 16'($urandom_range(2200));
                c.b = 16'($urandom_range(2200));
            end
            3:
            begin
                c.g = '0;
                c.b = '0;
            end
            default: ;
        endcase
        return c;
    endfunction

    // Stimulus: reset, directed cases, then random phases with count changes.
    initial
    begin : stimulus
        int cnt;
        int nled;
        int rnd_leds;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Single-LED frames: dark, full, each channel alone and rounding edges.
        send_led(16'h0000, 16'h0000, 16'h0000);
        send_led(16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_led(16'hFFFF, 16'h0000, 16'h0000);
        send_led(16'h0000, 16'hFFFF, 16'h0000);
        send_led(16'h0000, 16'h0000, 16'hFFFF);
        send_led(16'h0001, 16'h0000, 16'h0000);
        send_led(16'd2114, 16'd2114, 16'd2114);
        send_led(16'd2115, 16'd1000, 16'd1);
        send_led(16'h8000, 16'h4000, 16'h0001);
        send_led(16'hAAAA, 16'h5555, 16'hFFFF);
        send_led(16'h5555, 16'hAAAA, 16'h0000);
        drain();

        // A count of zero behaves as one.
        apb_write(REG_LED_COUNT, 32'd0);
        send_led(16'h1234, 16'h5678, 16'h9ABC);
        send_led(16'hFEDC, 16'hBA98, 16'h7654);
        drain();

        // A three-LED frame; a write to an unused address changes nothing.
        apb_write(REG_LED_COUNT, 32'd3);
        apb_write(REG_UNUSED, 32'h0000_0001);
        send_led(16'h0F0F, 16'hF0F0, 16'h00FF);
        send_led(16'hFF00, 16'h0000, 16'h0000);
        send_led(16'h0000, 16'h0000, 16'h0000);
        drain();

        // Count lowered mid-frame: the next LED closes the frame.
        apb_write(REG_LED_COUNT, 32'd5);
        send_led(16'h3333, 16'h6666, 16'h9999);
        send_led(16'hCCCC, 16'h0001, 16'h7FFF);
        drain();
        apb_write(REG_LED_COUNT, 32'd1);
        send_led(16'hFFFF, 16'h0000, 16'hFFFF);
        drain();

        // Count above the maximum saturates; then exactly the maximum,
        // then a smaller count ends the long frame.
        apb_write(REG_LED_COUNT, 32'd1023);
        send_led(16'h0101, 16'h0202, 16'h0303);
        send_led(16'hFFFF, 16'hFFFE, 16'hFFFD);
        send_led(16'h0000, 16'h0000, 16'h0000);
        drain();
        apb_write(REG_LED_COUNT, 32'd512);
        send_led(16'h8001, 16'h7FFE, 16'h0010);
        send_led(16'h00FF, 16'hFF00, 16'hF00F);
        drain();
        apb_write(REG_LED_COUNT, 32'd4);
        send_led(16'h4321, 16'h8765, 16'hCBA9);
        drain();

        // Random phases: new count (random upper data bits), then a burst of LEDs.
        rnd_leds = 0;
        while (rnd_leds < RANDOM_LEDS)
        begin
            case ($urandom_range(9))
                0: cnt = 1;
                1: cnt = 0;
                2: cnt = MAX_LEDS;
                3: cnt = $urandom_range(1023, MAX_LEDS + 1);
                4: cnt = 2;
                default: cnt = $urandom_range(40, 1);
            endcase
            apb_write(REG_LED_COUNT, ($urandom & 32'hFFFF_FC00) | cnt);
            if ($urandom_range(3) == 0)
                apb_write(REG_UNUSED, $urandom);
            calm <= (rnd_leds >= 80 && rnd_leds < 150);
            nled = $urandom_range(40, 1);
            repeat (nled)
            begin : one_led
                colour_t c;
                c = random_colour();
                send_led(c.r, c.g, c.b);
            end
            rnd_leds += nled;
            drain();
        end

        $display("Run covered %0d LEDs over %0d register writes:",
                 leds_accepted, reg_writes);
        $display("%0d frames closed, %0d bytes compared.", frames_seen, bytes_checked);
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Watchdog against a hung handshake.
    initial
    begin : watchdog
        #2_000_000;
        $display("Simulation timed out with %0d bytes still expected.", frame_bytes_due.size());
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== led_frame_brightness_encoder.f =====
hw/rtl/lfbe_pkg.sv
hw/rtl/lfbe_front.sv
hw/rtl/lfbe_queue.sv
hw/rtl/lfbe_div.sv
hw/rtl/lfbe_ser.sv
hw/rtl/led_frame_brightness_encoder.sv
sim/tb_led_frame_brightness_encoder.sv
